[src/jkwm_pkg.sv]
// Shared types and constants for the JK flip-flop window monitor.
// Used by the divider, the top-level sequencer, the checker and the testbench.
// No dependencies.
package jkwm_pkg;

    // Q1.16 probability format
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned PROB_W  = FRAC_W + 1;
    localparam int unsigned BIAS_W  = FRAC_W + 2;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned WSIZE_W = 11;
    localparam int unsigned CFG_W   = 17;
    localparam int unsigned IDX_W   = 2;

    localparam logic [PROB_W-1:0]  ONE_Q16   = PROB_W'(1) << FRAC_W;
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(PROB_W - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [WSIZE_W-1:0] WSIZE_RST = WSIZE_W'(1024);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_WINDOW_SIZE    = 2'd0,
        CFG_THEO_PROB      = 2'd1,
        CFG_BIAS_THRESHOLD = 2'd2
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEAVE,
        ST_DIV,
        ST_DONE
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[src/jk_flipflop_window_monitor.sv]
// JK flip-flop window monitor: applies J/K requests to a flip-flop, averages the
// last window_size output bits and flags bias beyond a threshold.
// Depends on jkwm_pkg, jkwm_div and jkwm_hist.
//
// Each request passes through the sequencer states in order: IDLE, where it is
// accepted and the bit leaving the window is read; LEAVE, which stores the new bit
// and updates the ones count; DIV, the bit-serial divider (one quotient bit per
// cycle); and DONE, which forms the bias and loads the output register. No new
// request is taken until the block is back in IDLE. The divider sets the rate.
// A result waiting in the output register does not block the next request; the
// block holds its result only if the previous one has not been taken yet.
// After a write to window_size the ones count is rebuilt from the history ring,
// one bit per cycle; s_axis_tready stays low until the recount is done. The
// history ring needs no clearing after reset.
module jk_flipflop_window_monitor #(
    parameter int unsigned WIN_MAX = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    // request channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [0] j_bit, [1] k_bit
    // result channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [0] q_bit, [17:1] window_prob,
                                         // [35:18] window_bias, [67:36] conv_index,
                                         // [99:68] items_seen
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data
);

    localparam int unsigned NW = $clog2(WIN_MAX + 1);
    localparam int unsigned AW = $clog2(WIN_MAX);
    localparam int unsigned PW = jkwm_pkg::PROB_W;
    localparam int unsigned BW = jkwm_pkg::BIAS_W;
    localparam int unsigned CW = jkwm_pkg::CNT_W;

    jkwm_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [jkwm_pkg::WSIZE_W-1:0] win_reg;
    logic [jkwm_pkg::CFG_W-1:0]   theo_reg;
    logic [jkwm_pkg::CFG_W-1:0]   thr_reg;
    logic                         rescan_reg;

    // Flip-flop and window state
    logic          q_reg;
    logic [CW-1:0] count_reg;
    logic [NW-1:0] ones_reg;
    logic [AW-1:0] wp_reg;
    logic [CW-1:0] conv_reg;
    logic [NW-1:0] n_reg;
    logic          leave_reg;

    // Recount state
    logic [NW-1:0] scan_left_reg;
    logic [AW-1:0] scan_addr_reg;
    logic          scan_pend_reg;

    // Output register
    logic          out_valid_reg;
    logic          out_q_reg;
    logic [PW-1:0] out_prob_reg;
    logic [BW-1:0] out_bias_reg;
    logic [CW-1:0] out_conv_reg;
    logic [CW-1:0] out_items_reg;

    // Control and datapath nets
    logic                  accept;
    logic                  win_write;
    logic                  out_free;
    logic                  j_in;
    logic                  k_in;
    logic                  q_new;
    logic [NW-1:0]         eff_win;
    logic [CW-1:0]         count_inc;
    logic [NW-1:0]         n_new;
    logic [NW-1:0]         scan_len;
    logic [CW-1:0]         back_sum;
    logic [AW-1:0]         leave_addr;
    logic [AW-1:0]         scan_first;
    logic [AW-1:0]         scan_addr_dec;
    logic [AW-1:0]         wp_inc;
    logic [NW-1:0]         ones_upd;
    logic                  scan_end;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  rd_bit;
    logic                  wr_en;
    logic                  div_start;
    jkwm_pkg::div_status_t div_st;
    logic [PW-1:0]         div_quo;
    logic [PW-1:0]         theo_c;
    logic [PW-1:0]         thr_c;
    logic signed [BW-1:0]  bias;
    logic [BW-1:0]         bias_mag;
    logic                  exceed;

    assign j_in      = s_axis_tdata[0];
    assign k_in      = s_axis_tdata[1];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign win_write = cfg_we && (cfg_index == jkwm_pkg::CFG_WINDOW_SIZE);

    // Effective window: zero counts as one, clamp to ring depth
    always_comb
    begin
        if (win_reg == '0)
        begin
            eff_win = NW'(1);
        end
        else if (CW'(win_reg) > CW'(WIN_MAX))
        begin
            eff_win = NW'(WIN_MAX);
        end
        else
        begin
            eff_win = NW'(win_reg);
        end
    end

    // Flip-flop update and window length for the incoming request
    always_comb
    begin
        unique case ({j_in, k_in})
            2'b00:   q_new = q_reg;
            2'b01:   q_new = 1'b0;
            2'b10:   q_new = 1'b1;
            default: q_new = !q_reg;
        endcase
        count_inc = (count_reg == jkwm_pkg::CNT_MAX) ? count_reg : count_reg + 1'b1;
        n_new     = (count_inc < CW'(eff_win)) ? NW'(count_inc) : eff_win;
        scan_len  = (count_reg < CW'(eff_win)) ? NW'(count_reg) : eff_win;
    end

    // Ring address arithmetic
    always_comb
    begin
        back_sum = CW'(wp_reg) + CW'(WIN_MAX) - CW'(eff_win);
        if (back_sum >= CW'(WIN_MAX))
        begin
            back_sum = back_sum - CW'(WIN_MAX);
        end
        leave_addr    = AW'(back_sum);
        scan_first    = (wp_reg == '0) ? AW'(WIN_MAX - 1) : wp_reg - 1'b1;
        scan_addr_dec = (scan_addr_reg == '0) ? AW'(WIN_MAX - 1) : scan_addr_reg - 1'b1;
        wp_inc        = (wp_reg == AW'(WIN_MAX - 1)) ? '0 : wp_reg + 1'b1;
        ones_upd      = ones_reg + NW'(q_reg) - NW'(leave_reg && rd_bit);
        scan_end      = (scan_left_reg == '0) && !scan_pend_reg;
    end

    // Bias against the expected probability
    always_comb
    begin
        theo_c   = (theo_reg > jkwm_pkg::ONE_Q16) ? jkwm_pkg::ONE_Q16 : theo_reg;
        thr_c    = (thr_reg > jkwm_pkg::ONE_Q16) ? jkwm_pkg::ONE_Q16 : thr_reg;
        bias     = signed'({1'b0, div_quo}) - signed'({1'b0, theo_c});
        bias_mag = bias[BW-1] ? BW'(-bias) : BW'(bias);
        exceed   = bias_mag > {1'b0, thr_c};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jkwm_pkg::ST_IDLE:
            begin
                if (rescan_reg)
                begin
                    state_next = jkwm_pkg::ST_SCAN;
                end
                else if (s_axis_tvalid)
                begin
                    state_next = jkwm_pkg::ST_LEAVE;
                end
            end
            jkwm_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = jkwm_pkg::ST_IDLE;
                end
            end
            jkwm_pkg::ST_LEAVE:
            begin
                state_next = jkwm_pkg::ST_DIV;
            end
            jkwm_pkg::ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = jkwm_pkg::ST_DONE;
                end
            end
            jkwm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = jkwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jkwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = leave_addr;
        wr_en         = 1'b0;
        div_start     = 1'b0;
        unique case (state_reg)
            jkwm_pkg::ST_IDLE:
            begin
                s_axis_tready = !rescan_reg;
                rd_en         = !rescan_reg && s_axis_tvalid;
            end
            jkwm_pkg::ST_SCAN:
            begin
                rd_en   = scan_left_reg != '0;
                rd_addr = scan_addr_reg;
            end
            jkwm_pkg::ST_LEAVE:
            begin
                wr_en     = 1'b1;
                div_start = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= jkwm_pkg::ST_IDLE;
            win_reg    <= jkwm_pkg::WSIZE_RST;
            theo_reg   <= '0;
            thr_reg    <= '0;
            rescan_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jkwm_pkg::CFG_WINDOW_SIZE:    win_reg  <= cfg_data[jkwm_pkg::WSIZE_W-1:0];
                    jkwm_pkg::CFG_THEO_PROB:      theo_reg <= cfg_data;
                    jkwm_pkg::CFG_BIAS_THRESHOLD: thr_reg  <= cfg_data;
                    default:                      thr_reg  <= thr_reg;
                endcase
            end
            // Drop the recount request once the pass starts; a new write raises it again
            if (win_write)
            begin
                rescan_reg <= 1'b1;
            end
            else if (state_reg == jkwm_pkg::ST_IDLE && rescan_reg)
            begin
                rescan_reg <= 1'b0;
            end
        end
    end

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= 1'b0;
            count_reg     <= '0;
            ones_reg      <= '0;
            wp_reg        <= '0;
            conv_reg      <= '0;
            n_reg         <= '0;
            leave_reg     <= 1'b0;
            scan_left_reg <= '0;
            scan_addr_reg <= '0;
            scan_pend_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                jkwm_pkg::ST_IDLE:
                begin
                    if (rescan_reg)
                    begin
                        ones_reg      <= '0;
                        scan_left_reg <= scan_len;
                        scan_addr_reg <= scan_first;
                        scan_pend_reg <= 1'b0;
                    end
                    else if (accept)
                    begin
                        q_reg     <= q_new;
                        count_reg <= count_inc;
                        n_reg     <= n_new;
                        leave_reg <= count_reg >= CW'(eff_win);
                    end
                end
                jkwm_pkg::ST_SCAN:
                begin
                    if (scan_left_reg != '0)
                    begin
                        scan_left_reg <= scan_left_reg - 1'b1;
                        scan_addr_reg <= scan_addr_dec;
                    end
                    scan_pend_reg <= scan_left_reg != '0;
                    if (scan_pend_reg)
                    begin
                        ones_reg <= ones_reg + NW'(rd_bit);
                    end
                end
                jkwm_pkg::ST_LEAVE:
                begin
                    ones_reg <= ones_upd;
                    wp_reg   <= wp_inc;
                end
                jkwm_pkg::ST_DONE:
                begin
                    if (out_free && exceed)
                    begin
                        conv_reg <= count_reg;
                    end
                end
                default:
                begin
                    leave_reg <= leave_reg;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == jkwm_pkg::ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == jkwm_pkg::ST_DONE && out_free)
        begin
            out_q_reg     <= q_reg;
            out_prob_reg  <= div_quo;
            out_bias_reg  <= bias;
            out_conv_reg  <= exceed ? count_reg : conv_reg;
            out_items_reg <= count_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_items_reg, out_conv_reg, out_bias_reg,
                            out_prob_reg, out_q_reg};

    jkwm_hist #(
        .DEPTH (WIN_MAX),
        .AW    (AW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_bit  (q_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_bit  (rd_bit)
    );

    jkwm_div #(
        .NW (NW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (ones_upd),
        .den    (n_reg),
        .status (div_st),
        .quo    (div_quo)
    );

    // The running count never exceeds the window it averages
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jkwm_pkg::ST_DIV) |-> (ones_reg <= n_reg))
        else $error("ones count exceeds window length");

    // An accepted request always moves on to the history update
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == jkwm_pkg::ST_LEAVE))
        else $error("accepted request did not reach history update");

    // The divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == jkwm_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

    // A new result comes only from the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == jkwm_pkg::ST_DONE))
        else $error("result loaded outside result state");

    // Windowed probability stays within one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_prob_reg <= jkwm_pkg::ONE_Q16))
        else $error("window probability above one");

endmodule

[src/jkwm_div.sv]
// Bit-serial restoring divider: floor(num * 2^16 / den) for num <= den.
// One quotient bit per cycle; a start while busy begins a new division.
// Depends on jkwm_pkg.
module jkwm_div #(
    parameter int unsigned NW = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NW-1:0]               num,
    input  logic [NW-1:0]               den,
    output jkwm_pkg::div_status_t       status,
    output logic [jkwm_pkg::PROB_W-1:0] quo
);

    logic                          busy_reg;
    logic [jkwm_pkg::STEP_W-1:0]   step_reg;
    logic [NW:0]                   rem_reg;
    logic [NW-1:0]                 den_reg;
    logic [jkwm_pkg::PROB_W-1:0]   quo_reg;
    logic                          ge;
    logic [NW:0]                   rem_sub;
    logic [NW:0]                   rem_next;

    // Trial subtract, keep remainder when it would go negative
    always_comb
    begin
        ge       = rem_reg >= {1'b0, den_reg};
        rem_sub  = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next = {rem_sub[NW-1:0], 1'b0};
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == jkwm_pkg::LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[jkwm_pkg::PROB_W-2:0], ge};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (step_reg == jkwm_pkg::LAST_STEP);
    assign quo         = quo_reg;

endmodule

[src/jkwm_hist.sv]
// Ring memory of recent flip-flop output bits, one write and one read port.
// Read data is registered. No dependencies.
module jkwm_hist #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_bit,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_bit
);

    logic mem [DEPTH];
    logic rd_bit_reg;

    // Store new bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

[verif/jkwm_checker.sv]
`timescale 1ns / 1ps
// Checker for the JK flip-flop window monitor: watches the request, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on jkwm_pkg for the register indexes and the Q1.16 constants.
module jkwm_checker #(
    parameter int unsigned WIN_MAX = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [0] j_bit, [1] k_bit
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,   // [0] q_bit, [17:1] window_prob,
                                         // [35:18] window_bias, [67:36] conv_index,
                                         // [99:68] items_seen
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data,
    output int unsigned  errors,
    output int unsigned  pending
);

    // Result fields, first field in the top bits so it maps onto tdata directly
    typedef struct packed {
        logic [31:0]        seen;
        logic [31:0]        conv;
        logic signed [17:0] bias;
        logic [16:0]        prob;
        logic               q_bit;
    } window_stats_t;

    // Shadow of the flip-flop, the history ring and the registers
    logic          q_now;
    logic [31:0]   seen_cnt;
    logic          ring [WIN_MAX];
    int unsigned   ring_ptr;
    logic [31:0]   conv_pt;
    logic [10:0]   win_cfg;
    logic [16:0]   theo_cfg;
    logic [16:0]   thr_cfg;

    window_stats_t window_stats_q [$];
    int unsigned   result_no;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Print one line per mismatch and count it
    task automatic report(input string what);
        errors++;
        $display("%0t ns: result %0d: %s", $time, result_no, what);
    endtask

    // Apply one J/K request and work out the monitor outputs it produces
    task automatic apply_jk(input logic j, input logic k, output window_stats_t r);
        int unsigned     span;
        int unsigned     ones;
        int unsigned     idx;
        longint unsigned prob;
        longint          theo;
        longint          thr;
        longint          bias;

        if (j && k)
            q_now = ~q_now;
        else if (j)
            q_now = 1'b1;
        else if (k)
            q_now = 1'b0;

        if (seen_cnt != jkwm_pkg::CNT_MAX)
            seen_cnt = seen_cnt + 32'd1;

        ring[ring_ptr] = q_now;
        ring_ptr = (ring_ptr + 1) % WIN_MAX;

        // window length: size clamped to 1..WIN_MAX, never more than items seen
        span = 32'(win_cfg);
        if (span == 0)
            span = 1;
        if (span > WIN_MAX)
            span = WIN_MAX;
        if (seen_cnt < span)
            span = seen_cnt;

        ones = 0;
        idx  = ring_ptr;
        for (int unsigned i = 0; i < span; i++)
        begin
            idx  = (idx + WIN_MAX - 1) % WIN_MAX;
            ones = ones + 32'(ring[idx]);
        end

        prob = (longint'(ones) << jkwm_pkg::FRAC_W) / longint'(span);
        theo = (theo_cfg > jkwm_pkg::ONE_Q16) ? longint'(jkwm_pkg::ONE_Q16)
                                              : longint'(theo_cfg);
        thr  = (thr_cfg > jkwm_pkg::ONE_Q16) ? longint'(jkwm_pkg::ONE_Q16)
                                             : longint'(thr_cfg);
        bias = longint'(prob) - theo;

        // strictly beyond the threshold latches the current count
        if (bias > thr || bias < -thr)
            conv_pt = seen_cnt;

        r.q_bit = q_now;
        r.prob  = prob[16:0];
        r.bias  = bias[17:0];
        r.conv  = conv_pt;
        r.seen  = seen_cnt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        window_stats_t got;
        window_stats_t want;

        if (!rst_n)
        begin
            q_now     = 1'b0;
            seen_cnt  = '0;
            ring_ptr  = 0;
            conv_pt   = '0;
            win_cfg   = jkwm_pkg::WSIZE_RST;
            theo_cfg  = '0;
            thr_cfg   = '0;
            result_no = 0;
            foreach (ring[i])
                ring[i] = 1'b0;
            window_stats_q.delete();
            pending = 0;
        end
        else
        begin
            // Compare a taken result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[99:0];
                if (m_axis_tdata[103:100] != 4'd0)
                    report($sformatf("pad bits not zero: %h", m_axis_tdata[103:100]));
                if (window_stats_q.size() == 0)
                    report("result with no request waiting");
                else
                begin
                    want = window_stats_q.pop_front();
                    if (got.q_bit !== want.q_bit)
                        report($sformatf("q_bit expected %0d got %0d",
                                         want.q_bit, got.q_bit));
                    if (got.prob !== want.prob)
                        report($sformatf("window_prob expected %0d got %0d",
                                         want.prob, got.prob));
                    if (got.bias !== want.bias)
                        report($sformatf("window_bias expected %0d got %0d",
                                         want.bias, got.bias));
                    if (got.conv !== want.conv)
                        report($sformatf("conv_index expected %0d got %0d",
                                         want.conv, got.conv));
                    if (got.seen !== want.seen)
                        report($sformatf("items_seen expected %0d got %0d",
                                         want.seen, got.seen));
                end
                result_no++;
            end

            // Predict for an accepted request
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_jk(s_axis_tdata[0], s_axis_tdata[1], want);
                window_stats_q.insert(window_stats_q.size(), want);
            end

            // Track register writes
            if (cfg_we)
            begin
                case (jkwm_pkg::cfg_idx_t'(cfg_index))
                    jkwm_pkg::CFG_WINDOW_SIZE:    win_cfg  = cfg_data[10:0];
                    jkwm_pkg::CFG_THEO_PROB:      theo_cfg = cfg_data;
                    jkwm_pkg::CFG_BIAS_THRESHOLD: thr_cfg  = cfg_data;
                    default: ;
                endcase
            end

            pending = window_stats_q.size();
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the JK flip-flop window monitor testbench: clock, reset, J/K requests,
// register writes, result back-pressure and the verdict.
// Depends on jkwm_pkg, jk_flipflop_window_monitor and jkwm_checker.
module testbench;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [0] j_bit, [1] k_bit
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // [0] q_bit, [17:1] window_prob,
                                  // [35:18] window_bias, [67:36] conv_index,
                                  // [99:68] items_seen
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [16:0]  cfg_data;

    int unsigned  errors;
    int unsigned  pending;
    bit           quiet;          // no gaps on either side while set

    jk_flipflop_window_monitor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    jkwm_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 16);
        else
            return $urandom_range(40, 200);
    endfunction

    // Offer one J/K request; entered and left at a falling edge
    task automatic send_req(input logic j, input logic k);
        int unsigned gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, k, j};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic cfg_write(input jkwm_pkg::cfg_idx_t idx, input logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Reconfigure while idle; window size last since it starts the recount
    task automatic set_config(input logic [16:0] win, input logic [16:0] theo,
                              input logic [16:0] thr);
        drain();
        repeat (25) @(negedge clk);
        cfg_write(jkwm_pkg::CFG_THEO_PROB, theo);
        cfg_write(jkwm_pkg::CFG_BIAS_THRESHOLD, thr);
        cfg_write(jkwm_pkg::CFG_WINDOW_SIZE, win);
    endtask

    // Result side back-pressure
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                stall_left = 0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left = gap_len();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Run limit
    initial
    begin
        #60_000_000;
        $display("jk_flipflop_window_monitor test failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned n_rand;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned pj;
        int unsigned pk;
        int unsigned r;
        logic [10:0] win;
        logic [16:0] theo;
        logic [16:0] thr;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = jkwm_pkg::CFG_WINDOW_SIZE;
        cfg_data      = '0;
        quiet         = 1'b1;
        n_rand        = 0;
        phase         = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: hold, set, hold, clear, toggle twice
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b0);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b1, 1'b1);
        send_req(1'b1, 1'b1);

        // Zero window acts as one; oversized probability and threshold saturate,
        // so the bias sits at zero or exactly at minus the threshold
        set_config(17'h1F800, 17'h1FFFF, 17'h1FFFF);
        send_req(1'b1, 1'b0);
        send_req(1'b1, 1'b1);
        send_req(1'b1, 1'b1);

        // Oversized window saturates to the ring depth
        set_config(17'd2047, 17'd65536, 17'd0);
        send_req(1'b0, 1'b1);
        send_req(1'b1, 1'b0);

        // Window of three: one third lands exactly on the threshold
        set_config(17'd3, 17'd0, 17'd21845);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b0);
        send_req(1'b0, 1'b0);

        // Full window at half probability
        set_config(17'd1024, 17'd32768, 17'd32768);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b1);

        // Random phases: fresh settings and J/K mix each time
        while (n_rand < 2000)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                win = 11'($urandom_range(1, 16));
            else if (r < 55)
                win = 11'($urandom_range(17, 1024));
            else if (r < 70)
                win = 11'($urandom_range(1000, 1024));
            else if (r < 85)
            begin
                case ($urandom_range(0, 3))
                    0:       win = 11'd0;
                    1:       win = 11'd1;
                    2:       win = 11'd1024;
                    default: win = 11'($urandom_range(1025, 2047));
                endcase
            end
            else
                win = 11'($urandom);

            r = $urandom_range(0, 99);
            if (r < 15)
                theo = 17'd0;
            else if (r < 25)
                theo = 17'd65536;
            else if (r < 40)
                theo = 17'($urandom_range(65537, 131071));
            else
                theo = 17'($urandom_range(0, 65536));

            r = $urandom_range(0, 99);
            if (r < 15)
                thr = 17'd0;
            else if (r < 25)
                thr = 17'($urandom_range(65536, 131071));
            else if (r < 60)
                thr = 17'($urandom_range(0, 4096));
            else
                thr = 17'($urandom_range(0, 65536));

            set_config({6'($urandom), win}, theo, thr);

            quiet     = ($urandom_range(0, 4) == 0);
            pj        = $urandom_range(0, 100);
            pk        = $urandom_range(0, 100);
            phase_len = $urandom_range(40, 250);
            for (int unsigned i = 0; i < phase_len; i++)
            begin
                // hold off once mid-phase until the block has drained
                if (phase == 0 && i == 20)
                    drain();
                send_req($urandom_range(0, 99) < pj, $urandom_range(0, 99) < pk);
                n_rand++;
            end
            phase++;
        end

        quiet = 1'b0;
        drain();
        repeat (40) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("jk_flipflop_window_monitor test passed");
        else
            $display("jk_flipflop_window_monitor test failed");
        $finish;
    end

endmodule
